// ===== sv/mse_pkg.sv =====
// shared constants, codes and the execute result type of the mips32 subset execute block
// no dependencies
package mse_pkg;

    localparam int          DATA_WORDS_DEFAULT = 1024;
    localparam int          REG_COUNT          = 32;
    localparam int          REG_IDX_W          = 5;
    localparam int          CFG_INDEX_W        = 2;
    localparam logic [31:0] TEXT_START_RESET   = 32'h0040_0000;
    localparam logic [31:0] DATA_BASE_RESET    = 32'h1000_0000;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_START = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_BASE  = 2'd1;

    // commands
    localparam logic [1:0] CMD_EXEC    = 2'd0;
    localparam logic [1:0] CMD_PRELOAD = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_ILLEGAL = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2b;

    // function codes under the special opcode
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    localparam logic [REG_IDX_W-1:0] REG_LINK = 5'd31;

    typedef struct packed {
        logic [31:0]          next_pc;
        logic                 pc_update;
        logic                 rf_we;
        logic [REG_IDX_W-1:0] rf_idx;
        logic [31:0]          rf_val;
        logic                 mem_rd;
        logic                 mem_wr;
        logic [31:0]          mem_off;
        logic [31:0]          mem_wdata;
        logic                 load_we;
        logic [REG_IDX_W-1:0] load_idx;
        logic                 store_enable;
        logic [31:0]          store_address;
        logic [1:0]           status;
        logic                 to_mem;
    } exec_t;

endpackage

// ===== sv/mse_regfile.sv =====
// 32-entry register file, two registered read ports and one write port
// valid bits make never-written entries read as zero; uses mse_pkg
module mse_regfile (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [mse_pkg::REG_IDX_W-1:0] rd_addr_a,
    input  logic [mse_pkg::REG_IDX_W-1:0] rd_addr_b,
    output logic [31:0]                   rd_data_a,
    output logic [31:0]                   rd_data_b,
    input  logic                          wr_en,
    input  logic [mse_pkg::REG_IDX_W-1:0] wr_addr,
    input  logic [31:0]                   wr_data
);

    logic [31:0]                   mem [mse_pkg::REG_COUNT];
    logic [mse_pkg::REG_COUNT-1:0] valid_reg;
    logic [31:0]                   data_a_reg;
    logic [31:0]                   data_b_reg;
    logic                          valid_a_reg;
    logic                          valid_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            data_a_reg <= mem[rd_addr_a];
            data_b_reg <= mem[rd_addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                valid_a_reg <= valid_reg[rd_addr_a];
                valid_b_reg <= valid_reg[rd_addr_b];
            end
        end
    end

    assign rd_data_a = valid_a_reg ? data_a_reg : 32'd0;
    assign rd_data_b = valid_b_reg ? data_b_reg : 32'd0;

endmodule

// ===== sv/mse_dmem.sv =====
// word-organized data memory with registered read and a clearing pass after reset
// uses no package items
module mse_dmem #(
    parameter int DATA_WORDS = 1024,
    parameter int AW         = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic          wr_en,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wr_data,
    output logic [31:0]   rd_data,
    output logic          clear_busy
);

    logic [31:0]   mem [DATA_WORDS];
    logic [31:0]   rd_data_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DATA_WORDS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= 32'd0;
        end else if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clr_busy_reg;

endmodule

// ===== sv/mse_exec.sv =====
// decode and execute of one item: alu, branch target, data address and range check
// uses mse_pkg for codes and the exec_t result
module mse_exec #(
    parameter int DATA_WORDS = 1024
) (
    input  logic [1:0]     cmd,
    input  logic [31:0]    iw,
    input  logic [31:0]    haddr,
    input  logic [31:0]    hdata,
    input  logic [31:0]    a,
    input  logic [31:0]    b,
    input  logic [31:0]    pc,
    input  logic [31:0]    data_base,
    output mse_pkg::exec_t res
);

    localparam logic [31:0] LIMIT = 32'(DATA_WORDS * 4);

    logic [5:0]                    op;
    logic [5:0]                    fn;
    logic [mse_pkg::REG_IDX_W-1:0] rt;
    logic [mse_pkg::REG_IDX_W-1:0] rd;
    logic [4:0]                    sh;
    logic [31:0]                   imm;
    logic [31:0]                   simm;
    logic [31:0]                   seq;
    logic [31:0]                   eff;
    logic [31:0]                   addr;
    logic [31:0]                   off;
    logic                          ok;
    logic                          wr;
    logic [mse_pkg::REG_IDX_W-1:0] dst;
    logic [31:0]                   val;

    assign op   = iw[31:26];
    assign rt   = iw[20:16];
    assign rd   = iw[15:11];
    assign sh   = iw[10:6];
    assign fn   = iw[5:0];
    assign imm  = {16'd0, iw[15:0]};
    assign simm = {{16{iw[15]}}, iw[15:0]};
    assign seq  = pc + 32'd4;
    assign eff  = a + simm;
    assign addr = (cmd == mse_pkg::CMD_EXEC) ? eff : haddr;
    assign off  = addr - data_base;
    assign ok   = off < LIMIT;

    always_comb begin
        res         = '0;
        res.next_pc = pc;
        res.status  = mse_pkg::STATUS_OK;
        res.mem_off = off;
        wr          = 1'b0;
        dst         = '0;
        val         = 32'd0;
        case (cmd)
            mse_pkg::CMD_PRELOAD: begin
                if (ok) begin
                    res.mem_wr    = 1'b1;
                    res.mem_wdata = hdata;
                end else begin
                    res.status = mse_pkg::STATUS_RANGE;
                end
            end
            mse_pkg::CMD_READ: begin
                if (ok) begin
                    res.mem_rd = 1'b1;
                end else begin
                    res.status = mse_pkg::STATUS_RANGE;
                end
            end
            mse_pkg::CMD_EXEC: begin
                res.next_pc   = seq;
                res.pc_update = 1'b1;
                case (op)
                    mse_pkg::OP_SPECIAL: begin
                        dst = rd;
                        wr  = 1'b1;
                        case (fn)
                            mse_pkg::FN_ADDU: val = a + b;
                            mse_pkg::FN_AND:  val = a & b;
                            mse_pkg::FN_NOR:  val = ~(a | b);
                            mse_pkg::FN_OR:   val = a | b;
                            mse_pkg::FN_SLTU: val = {31'd0, a < b};
                            mse_pkg::FN_SLL:  val = b << sh;
                            mse_pkg::FN_SRL:  val = b >> sh;
                            mse_pkg::FN_SUBU: val = a - b;
                            mse_pkg::FN_JR: begin
                                wr          = 1'b0;
                                res.next_pc = a;
                            end
                            default: begin
                                wr         = 1'b0;
                                res.status = mse_pkg::STATUS_ILLEGAL;
                            end
                        endcase
                    end
                    mse_pkg::OP_J: begin
                        res.next_pc = {seq[31:28], iw[25:0], 2'b00};
                    end
                    mse_pkg::OP_JAL: begin
                        res.next_pc = {seq[31:28], iw[25:0], 2'b00};
                        wr          = 1'b1;
                        dst         = mse_pkg::REG_LINK;
                        val         = pc + 32'd8;
                    end
                    mse_pkg::OP_ADDIU: begin wr = 1'b1; dst = rt; val = eff; end
                    mse_pkg::OP_ANDI:  begin wr = 1'b1; dst = rt; val = a & imm; end
                    mse_pkg::OP_LUI:   begin wr = 1'b1; dst = rt; val = {iw[15:0], 16'd0}; end
                    mse_pkg::OP_ORI:   begin wr = 1'b1; dst = rt; val = a | imm; end
                    mse_pkg::OP_SLTIU: begin wr = 1'b1; dst = rt; val = {31'd0, a < simm}; end
                    mse_pkg::OP_LW: begin
                        if (ok) begin
                            res.mem_rd   = 1'b1;
                            res.load_we  = rt != '0;
                            res.load_idx = rt;
                        end else begin
                            res.status = mse_pkg::STATUS_RANGE;
                        end
                    end
                    mse_pkg::OP_SW: begin
                        if (ok) begin
                            res.mem_wr        = 1'b1;
                            res.mem_wdata     = b;
                            res.store_enable  = 1'b1;
                            res.store_address = eff;
                        end else begin
                            res.status = mse_pkg::STATUS_RANGE;
                        end
                    end
                    mse_pkg::OP_BEQ: begin
                        if (a == b) begin
                            res.next_pc = seq + {simm[29:0], 2'b00};
                        end
                    end
                    mse_pkg::OP_BNE: begin
                        if (a != b) begin
                            res.next_pc = seq + {simm[29:0], 2'b00};
                        end
                    end
                    default: res.status = mse_pkg::STATUS_ILLEGAL;
                endcase
            end
            default: res.status = mse_pkg::STATUS_ILLEGAL;
        endcase
        // register zero is never written
        res.rf_we  = wr && (dst != '0);
        res.rf_idx = res.rf_we ? dst : '0;
        res.rf_val = res.rf_we ? val : 32'd0;
        res.to_mem = res.mem_rd;
    end

endmodule

// ===== sv/mips32_subset_execute.sv =====
// top level of the mips32 subset execute block: handshake, pc, forwarding and result register
// depends on mse_pkg, mse_regfile, mse_dmem and mse_exec
//
// Usage: one input beat on s_* carries a command (execute an instruction word,
// preload a data word, read a data word back) and gives exactly one result beat
// on m_*. Both channels use valid/ready; cfg_* writes text_start (also loads the
// pc) or data_base and is always ready; write it only while the block is idle.
// Flow: an item's result is registered in the output register; lw and data reads
// first pass through the registered data memory read and the memory stage.
// Throughput: one item per cycle while m_ready stays high, except after lw and
// data reads, since the next item waits for the data memory read port and the
// register file writeback. Register file reads are issued at accept; the
// last register write is forwarded so dependent instructions issue back to back.
// Reset: the pc takes TEXT_START_RESET, the register file reads as zero at once, and
// the data memory is cleared one word a cycle, so s_ready stays low after reset
// is released until the clearing pass ends.
// Stall: a result waits in the output register while m_ready is low; one more
// item can be held in the execute stage behind it, then s_ready drops.
module mips32_subset_execute #(
    parameter int DATA_WORDS = mse_pkg::DATA_WORDS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mse_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_command,
    input  logic [31:0]                     s_instruction_word,
    input  logic [31:0]                     s_host_address,
    input  logic [31:0]                     s_host_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [31:0]                     m_next_pc,
    output logic                            m_reg_write_enable,
    output logic [4:0]                      m_reg_index,
    output logic [31:0]                     m_reg_value,
    output logic                            m_store_enable,
    output logic [31:0]                     m_store_address,
    output logic [31:0]                     m_store_data,
    output logic [31:0]                     m_read_data,
    output logic [1:0]                      m_status
);

    localparam int AW = $clog2(DATA_WORDS);

    logic        s_accept;
    logic        cfg_accept;
    logic        out_free;
    logic        e_leave;
    logic        mst_leave;
    logic        clear_busy;

    logic [31:0] pc_reg;
    logic [31:0] data_base_reg;

    // execute stage
    logic        e_valid_reg;
    logic [1:0]  e_cmd_reg;
    logic [31:0] e_iw_reg;
    logic [31:0] e_haddr_reg;
    logic [31:0] e_hdata_reg;

    // memory stage, lw and data reads only
    logic                          mst_valid_reg;
    logic [31:0]                   mst_next_pc_reg;
    logic                          mst_load_we_reg;
    logic [mse_pkg::REG_IDX_W-1:0] mst_load_idx_reg;

    // last register write, forwarded over the register file read
    logic                          fwd_valid_reg;
    logic [mse_pkg::REG_IDX_W-1:0] fwd_idx_reg;
    logic [31:0]                   fwd_val_reg;

    logic                          out_valid_reg;
    logic [31:0]                   out_next_pc_reg;
    logic                          out_we_reg;
    logic [4:0]                    out_idx_reg;
    logic [31:0]                   out_val_reg;
    logic                          out_se_reg;
    logic [31:0]                   out_saddr_reg;
    logic [31:0]                   out_sdata_reg;
    logic [31:0]                   out_rdata_reg;
    logic [1:0]                    out_status_reg;

    logic [31:0]                   rf_a;
    logic [31:0]                   rf_b;
    logic [31:0]                   op_a;
    logic [31:0]                   op_b;
    logic                          rf_wr_en;
    logic [mse_pkg::REG_IDX_W-1:0] rf_wr_addr;
    logic [31:0]                   rf_wr_data;
    logic [31:0]                   dm_rdata;
    mse_pkg::exec_t                res;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign out_free   = !out_valid_reg || m_ready;
    assign e_leave    = e_valid_reg && (res.to_mem || out_free);
    assign mst_leave  = mst_valid_reg && out_free;
    assign s_ready    = !clear_busy && (!mst_valid_reg || mst_leave)
                        && (!e_valid_reg || (e_leave && !res.to_mem));
    assign s_accept   = s_valid && s_ready;

    mse_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_accept),
        .rd_addr_a (s_instruction_word[25:21]),
        .rd_addr_b (s_instruction_word[20:16]),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b),
        .wr_en     (rf_wr_en),
        .wr_addr   (rf_wr_addr),
        .wr_data   (rf_wr_data)
    );

    assign op_a = (fwd_valid_reg && fwd_idx_reg == e_iw_reg[25:21]) ? fwd_val_reg : rf_a;
    assign op_b = (fwd_valid_reg && fwd_idx_reg == e_iw_reg[20:16]) ? fwd_val_reg : rf_b;

    mse_exec #(
        .DATA_WORDS (DATA_WORDS)
    ) u_exec (
        .cmd       (e_cmd_reg),
        .iw        (e_iw_reg),
        .haddr     (e_haddr_reg),
        .hdata     (e_hdata_reg),
        .a         (op_a),
        .b         (op_b),
        .pc        (pc_reg),
        .data_base (data_base_reg),
        .res       (res)
    );

    mse_dmem #(
        .DATA_WORDS (DATA_WORDS),
        .AW         (AW)
    ) u_dmem (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (e_leave && res.mem_rd),
        .wr_en      (e_leave && res.mem_wr),
        .addr       (res.mem_off[2 +: AW]),
        .wr_data    (res.mem_wdata),
        .rd_data    (dm_rdata),
        .clear_busy (clear_busy)
    );

    // e and the memory stage are never occupied together, so one write port suffices
    assign rf_wr_en   = (e_leave && res.rf_we) || (mst_leave && mst_load_we_reg);
    assign rf_wr_addr = mst_valid_reg ? mst_load_idx_reg : res.rf_idx;
    assign rf_wr_data = mst_valid_reg ? dm_rdata : res.rf_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= mse_pkg::TEXT_START_RESET;
            data_base_reg <= mse_pkg::DATA_BASE_RESET;
            e_valid_reg   <= 1'b0;
            mst_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_accept && cfg_index == mse_pkg::CFG_TEXT_START) begin
                pc_reg <= cfg_data;
            end else if (e_leave && res.pc_update) begin
                pc_reg <= res.next_pc;
            end
            if (cfg_accept && cfg_index == mse_pkg::CFG_DATA_BASE) begin
                data_base_reg <= cfg_data;
            end

            if (s_accept) begin
                e_valid_reg <= 1'b1;
            end else if (e_leave) begin
                e_valid_reg <= 1'b0;
            end

            if (e_leave && res.to_mem) begin
                mst_valid_reg <= 1'b1;
            end else if (mst_leave) begin
                mst_valid_reg <= 1'b0;
            end

            if (rf_wr_en) begin
                fwd_valid_reg <= 1'b1;
            end

            if (mst_leave || (e_leave && !res.to_mem)) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            e_cmd_reg   <= s_command;
            e_iw_reg    <= s_instruction_word;
            e_haddr_reg <= s_host_address;
            e_hdata_reg <= s_host_data;
        end
        if (e_leave && res.to_mem) begin
            mst_next_pc_reg  <= res.next_pc;
            mst_load_we_reg  <= res.load_we;
            mst_load_idx_reg <= res.load_idx;
        end
        if (rf_wr_en) begin
            fwd_idx_reg <= rf_wr_addr;
            fwd_val_reg <= rf_wr_data;
        end
        if (mst_leave) begin
            out_next_pc_reg <= mst_next_pc_reg;
            out_we_reg      <= mst_load_we_reg;
            out_idx_reg     <= mst_load_we_reg ? mst_load_idx_reg : 5'd0;
            out_val_reg     <= mst_load_we_reg ? dm_rdata : 32'd0;
            out_se_reg      <= 1'b0;
            out_saddr_reg   <= 32'd0;
            out_sdata_reg   <= 32'd0;
            out_rdata_reg   <= dm_rdata;
            out_status_reg  <= mse_pkg::STATUS_OK;
        end else if (e_leave && !res.to_mem) begin
            out_next_pc_reg <= res.next_pc;
            out_we_reg      <= res.rf_we;
            out_idx_reg     <= res.rf_idx;
            out_val_reg     <= res.rf_val;
            out_se_reg      <= res.store_enable;
            out_saddr_reg   <= res.store_address;
            out_sdata_reg   <= res.store_enable ? res.mem_wdata : 32'd0;
            out_rdata_reg   <= 32'd0;
            out_status_reg  <= res.status;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_next_pc          = out_next_pc_reg;
    assign m_reg_write_enable = out_we_reg;
    assign m_reg_index        = out_idx_reg;
    assign m_reg_value        = out_val_reg;
    assign m_store_enable     = out_se_reg;
    assign m_store_address    = out_saddr_reg;
    assign m_store_data       = out_sdata_reg;
    assign m_read_data        = out_rdata_reg;
    assign m_status           = out_status_reg;

endmodule

// ===== sv/mse_checker.sv =====
// port-level checks for mips32_subset_execute, attached by the bind at the end
// uses mse_pkg for status constants
module mse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_next_pc,
    input logic        m_reg_write_enable,
    input logic [4:0]  m_reg_index,
    input logic        m_store_enable,
    input logic [1:0]  m_status
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_next_pc) && $stable(m_status))
        else $error("result beat changed while stalled");

    // clearing pass keeps input closed right after reset
    a_reset_closed: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block open right after reset");

    // register zero is never reported as written
    a_no_reg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reg_write_enable |-> m_reg_index != 5'd0)
        else $error("write to register zero reported");

    // a faulting or illegal item writes nothing
    a_fault_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != mse_pkg::STATUS_OK |-> !m_reg_write_enable && !m_store_enable)
        else $error("faulting item reported a write");

    // one item never both stores and writes a register
    a_store_xor_reg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_store_enable && m_reg_write_enable))
        else $error("store and register write in one beat");

endmodule

bind mips32_subset_execute mse_checker u_checker (.*);
